FILE: rtl/sram_bank_address_mapper_core_assert.svh
// ----------------------------------------------------------------------------
// sram bank address mapper assertion macros
// ----------------------------------------------------------------------------
`ifndef SRAM_BANK_ADDRESS_MAPPER_CORE_ASSERT_SVH
`define SRAM_BANK_ADDRESS_MAPPER_CORE_ASSERT_SVH

// same-cycle implication
`define SBAM_ASSERT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sbam assertion failed");

// next-cycle implication
`define SBAM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sbam assertion failed");

`endif

FILE: rtl/sbam_pkg.sv
// ----------------------------------------------------------------------------
// sbam_pkg
// types, register indexes and helper functions of the bank address mapper
// ----------------------------------------------------------------------------
`default_nettype none
package sbam_pkg;

	localparam int ADDR_W = 32;
	localparam int BANK_W = 6;
	localparam int CAP_W  = 33;
	localparam int DATA_W = 72;
	localparam int IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_CAPACITY  = 3'd1,
		REG_BANKS     = 3'd2,
		REG_STRIPE    = 3'd3,
		REG_GROUPS    = 3'd4,
		REG_SHIFT     = 3'd5,
		REG_GRP_FIRST = 3'd6,
		REG_XOR_GRP   = 3'd7
	} reg_idx_t;

	localparam logic [1:0] MODE_XOR    = 2'd1;
	localparam logic [1:0] MODE_CONTIG = 2'd2;

	typedef struct packed {
		logic              contig;
		logic              use_xor;
		logic [2:0]        lb;
		logic [3:0]        ls;
		logic [2:0]        lg;
		logic [2:0]        lp;
		logic [4:0]        shift;
		logic              gfo;
		logic              xwg;
		logic [CAP_W-1:0]  capacity;
		logic [CAP_W-1:0]  slab;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic              err;
		logic [ADDR_W-1:0] rem;
		logic [BANK_W-1:0] quo;
		logic [BANK_W-1:0] bank;
		logic [ADDR_W-1:0] local_off;
		logic [ADDR_W-1:0] off;
		logic [ADDR_W-1:0] addr;
	} item_t;

	function automatic logic [2:0] msb7(input logic [6:0] x);
		logic [2:0] r;
		r = '0;
		for (int i = 0; i < 7; i++) begin
			if (x[i]) r = 3'(i);
		end
		return r;
	endfunction

	function automatic logic [3:0] msb12(input logic [11:0] x);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 12; i++) begin
			if (x[i]) r = 4'(i);
		end
		return r;
	endfunction

	function automatic logic [BANK_W-1:0] lowmask(input logic [2:0] n);
		return BANK_W'((7'd1 << n) - 7'd1);
	endfunction

	function automatic logic [BANK_W-1:0] swizzle(input logic [BANK_W-1:0] bk,
			input logic [ADDR_W-1:0] row, input cfg_t c);
		logic [BANK_W-1:0] mask;
		logic [BANK_W-1:0] key;
		mask = c.xwg ? lowmask(c.lp) : lowmask(c.lb);
		key  = BANK_W'(row >> c.shift) & mask;
		if (c.xwg && c.gfo)
			return (bk & lowmask(c.lg)) | BANK_W'(((bk >> c.lg) ^ key) << c.lg);
		return bk ^ key;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/sbam_cfg.sv
// ----------------------------------------------------------------------------
// sbam_cfg
// configuration registers and the decoded field widths derived from them
// ----------------------------------------------------------------------------
`default_nettype none
module sbam_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [sbam_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [sbam_pkg::CAP_W-1:0]  cfg_wdata,
	output sbam_pkg::cfg_t                   cfg
);

	logic [1:0]                 mode_q;
	logic [sbam_pkg::CAP_W-1:0] cap_q;
	logic [6:0]                 banks_q;
	logic [11:0]                stripe_q;
	logic [6:0]                 groups_q;
	logic [4:0]                 shift_q;
	logic                       gfo_q;
	logic                       xwg_q;
	logic [2:0]                 lb;
	logic [2:0]                 lg_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			cap_q    <= 33'd65536;
			banks_q  <= 7'd8;
			stripe_q <= 12'd64;
			groups_q <= 7'd1;
			shift_q  <= '0;
			gfo_q    <= 1'b0;
			xwg_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (sbam_pkg::reg_idx_t'(cfg_index))
				sbam_pkg::REG_MODE:      mode_q   <= cfg_wdata[1:0];
				sbam_pkg::REG_CAPACITY:  cap_q    <= cfg_wdata;
				sbam_pkg::REG_BANKS:     banks_q  <= cfg_wdata[6:0];
				sbam_pkg::REG_STRIPE:    stripe_q <= cfg_wdata[11:0];
				sbam_pkg::REG_GROUPS:    groups_q <= cfg_wdata[6:0];
				sbam_pkg::REG_SHIFT:     shift_q  <= cfg_wdata[4:0];
				sbam_pkg::REG_GRP_FIRST: gfo_q    <= cfg_wdata[0];
				sbam_pkg::REG_XOR_GRP:   xwg_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lb     = sbam_pkg::msb7(banks_q);
		lg_raw = sbam_pkg::msb7(groups_q);
		cfg.contig   = (mode_q == sbam_pkg::MODE_CONTIG);
		cfg.use_xor  = (mode_q == sbam_pkg::MODE_XOR);
		cfg.lb       = lb;
		cfg.ls       = (stripe_q < 12'd8) ? 4'd3 : sbam_pkg::msb12(stripe_q);
		cfg.lg       = (lg_raw > lb) ? lb : lg_raw;
		cfg.lp       = lb - cfg.lg;
		cfg.shift    = shift_q;
		cfg.gfo      = gfo_q;
		cfg.xwg      = xwg_q;
		cfg.capacity = cap_q;
		cfg.slab     = cap_q >> lb;
	end

endmodule
`default_nettype wire

FILE: rtl/sbam_divstep.sv
// ----------------------------------------------------------------------------
// sbam_divstep
// two restoring division steps of the slab index, quotient bits hi and hi-1
// ----------------------------------------------------------------------------
`default_nettype none
module sbam_divstep (
	input  wire logic [sbam_pkg::ADDR_W-1:0] rem_i,
	input  wire logic [sbam_pkg::BANK_W-1:0] quo_i,
	input  wire logic [sbam_pkg::CAP_W-1:0]  slab,
	input  wire logic [2:0]                  hi,
	output logic      [sbam_pkg::ADDR_W-1:0] rem_o,
	output logic      [sbam_pkg::BANK_W-1:0] quo_o
);

	logic [38:0] d_hi;
	logic [38:0] d_lo;
	logic [2:0]  lo;
	logic [sbam_pkg::ADDR_W-1:0] r_mid;

	always_comb begin
		lo    = hi - 3'd1;
		d_hi  = {6'b0, slab} << hi;
		d_lo  = {6'b0, slab} << lo;
		quo_o = quo_i;
		r_mid = rem_i;
		if ({7'b0, rem_i} >= d_hi) begin
			r_mid     = rem_i - d_hi[31:0];
			quo_o[hi] = 1'b1;
		end
		rem_o = r_mid;
		if ({7'b0, r_mid} >= d_lo) begin
			rem_o     = r_mid - d_lo[31:0];
			quo_o[lo] = 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sram_bank_address_mapper_core.sv
// ----------------------------------------------------------------------------
// sram_bank_address_mapper_core
// flat address to bank and offset mapper, and its inverse
// ----------------------------------------------------------------------------
// items enter on the s_ group: s_tuser is the kind (0 forward, 1 inverse),
// s_tdata carries flat address, bank and offset. results leave on the m_
// group: m_tdata carries bank, offset and address, m_tuser the range error.
// m_tvalid rises once an item has passed stages s1 to s4. one item per cycle is
// taken and delivered while m_tready is high; the four-stage pipe's contiguous
// slab division retires two quotient bits in each stage after s1. configuration
// is written through cfg_we, cfg_index and cfg_wdata while the pipe is empty, a
// rule the user keeps: the block does not enforce it. reset restores the default
// registers and empties the pipe. when the receiver stalls, bubbles still drain
// forward, each stage holds its item; s_tready drops only once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none
module sram_bank_address_mapper_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sbam_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [sbam_pkg::CAP_W-1:0]   cfg_wdata,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// flat_address, bank_in, offset_in, zero pad
	input  wire logic [sbam_pkg::DATA_W-1:0]  s_tdata,
	// kind
	input  wire logic                         s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// bank_out, offset_out, address_out, zero pad
	output logic      [sbam_pkg::DATA_W-1:0]  m_tdata,
	// range_error
	output logic                              m_tuser
);

	sbam_pkg::cfg_t  cfg;
	sbam_pkg::item_t it_s1, it_s2, it_s3, it_s4;
	sbam_pkg::item_t nx1, nx2, nx3, nx4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic [31:0] a_in, off_in;
	logic [5:0]  b_in;
	logic [31:0] d2_rem, d3_rem, d4_rem;
	logic [5:0]  d2_quo, d3_quo, d4_quo;
	logic [31:0] f_row, i_row, f_q;
	logic [5:0]  f_bk, f_sw, i_bk, i_sw;
	logic [31:0] smask;
	logic [32:0] slabx;

	sbam_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .cfg(cfg)
	);

	sbam_divstep u_div2 (.rem_i(it_s1.rem), .quo_i(it_s1.quo), .slab(cfg.slab),
		.hi(3'd5), .rem_o(d2_rem), .quo_o(d2_quo));
	sbam_divstep u_div3 (.rem_i(it_s2.rem), .quo_i(it_s2.quo), .slab(cfg.slab),
		.hi(3'd3), .rem_o(d3_rem), .quo_o(d3_quo));
	sbam_divstep u_div4 (.rem_i(it_s3.rem), .quo_i(it_s3.quo), .slab(cfg.slab),
		.hi(3'd1), .rem_o(d4_rem), .quo_o(d4_quo));

	assign rdy4     = !v_s4 || m_tready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	// range checks
	always_comb begin
		a_in   = s_tdata[31:0];
		b_in   = s_tdata[37:32];
		off_in = s_tdata[69:38];
		slabx  = cfg.slab << cfg.lb;
		nx1           = '0;
		nx1.kind      = s_tuser;
		nx1.rem       = a_in;
		nx1.bank      = b_in;
		nx1.local_off = off_in;
		if (cfg.slab == '0)
			nx1.err = 1'b1;
		else if (!s_tuser)
			nx1.err = ({1'b0, a_in} >= cfg.capacity) ||
				(cfg.contig && ({1'b0, a_in} >= slabx));
		else
			nx1.err = ((b_in >> cfg.lb) != '0) || ({1'b0, off_in} >= cfg.slab);
	end

	// interleave mapping and first division steps
	always_comb begin
		smask = 32'((33'd1 << cfg.ls) - 33'd1);
		f_q   = it_s1.rem >> cfg.ls;
		f_row = f_q >> cfg.lb;
		f_bk  = f_q[5:0] & sbam_pkg::lowmask(cfg.lb);
		f_sw  = cfg.use_xor ? sbam_pkg::swizzle(f_bk, f_row, cfg) : f_bk;
		i_row = it_s1.local_off >> cfg.ls;
		i_bk  = it_s1.bank;
		if (cfg.gfo)
			i_bk = ((i_bk & sbam_pkg::lowmask(cfg.lp)) << cfg.lg) | (i_bk >> cfg.lp);
		i_sw  = cfg.use_xor ? sbam_pkg::swizzle(i_bk, i_row, cfg) : i_bk;
		nx2 = it_s1;
		if (cfg.contig) begin
			if (!it_s1.kind) begin
				nx2.rem = d2_rem;
				nx2.quo = d2_quo;
			end else begin
				nx2.addr = 32'({27'b0, it_s1.bank} * cfg.slab);
			end
		end else if (!it_s1.kind) begin
			nx2.bank = cfg.gfo ?
				(((f_sw & sbam_pkg::lowmask(cfg.lg)) << cfg.lp) | (f_sw >> cfg.lg)) : f_sw;
			nx2.off  = (f_row << cfg.ls) | (it_s1.rem & smask);
		end else begin
			nx2.addr = (((i_row << cfg.lb) | {26'b0, i_sw}) << cfg.ls) |
				(it_s1.local_off & smask);
		end
	end

	always_comb begin
		nx3 = it_s2;
		if (cfg.contig) begin
			if (!it_s2.kind) begin
				nx3.rem = d3_rem;
				nx3.quo = d3_quo;
			end else begin
				nx3.addr = it_s2.addr + it_s2.local_off;
			end
		end
	end

	// last division steps and result cleanup
	always_comb begin
		nx4 = it_s3;
		if (cfg.contig && !it_s3.kind) begin
			nx4.bank = d4_quo;
			nx4.off  = d4_rem;
		end
		if (it_s3.kind) begin
			nx4.bank = '0;
			nx4.off  = '0;
		end else begin
			nx4.addr = '0;
		end
		if (it_s3.err) begin
			nx4.bank = '0;
			nx4.off  = '0;
			nx4.addr = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) it_s1 <= nx1;
		if (rdy2) it_s2 <= nx2;
		if (rdy3) it_s3 <= nx3;
		if (rdy4) it_s4 <= nx4;
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {2'b0, it_s4.addr, it_s4.off, it_s4.bank};
	assign m_tuser  = it_s4.err;

endmodule
`default_nettype wire

FILE: rtl/sbam_checker.sv
// ----------------------------------------------------------------------------
// sbam_checker
// port-level checks of the bank address mapper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "sram_bank_address_mapper_core_assert.svh"
module sbam_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tready,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [sbam_pkg::DATA_W-1:0] m_tdata,
	input wire logic                        m_tuser
);

	`SBAM_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`SBAM_ASSERT(a_err_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	`SBAM_ASSERT(a_one_direction, clk, arst_n, m_tvalid, (m_tdata[37:0] == '0) || (m_tdata[69:38] == '0))
	`SBAM_ASSERT(a_flow_through, clk, arst_n, m_tready, s_tready)

endmodule

bind sram_bank_address_mapper_core sbam_checker u_sbam_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
